// ===== rtl/stereo_highpass_exciter_compressor_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef STEREO_HIGHPASS_EXCITER_COMPRESSOR_MACROS_SVH
`define STEREO_HIGHPASS_EXCITER_COMPRESSOR_MACROS_SVH

// Condition must hold at every edge outside reset.
`define SHEC_ASSERT_ALWAYS(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SHEC_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHEC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/shec_pkg.sv =====
package shec_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int LP_STAGES    = 3;
  localparam int NUM_LP       = 2 * LP_STAGES;
  localparam int STAGE_W      = (LP_STAGES > 1) ? $clog2(LP_STAGES) : 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH_LIN     = 3'd0,
    REG_THRESH_DB      = 3'd1,
    REG_RELEASE_GROWTH = 3'd2,
    REG_LP_POLE        = 3'd3,
    REG_WET_GAIN       = 3'd4,
    REG_DRY_GAIN       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_in;
    logic signed [SAMPLE_WIDTH-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic [24:0]        thresh_lin;
    logic signed [14:0] thresh_db;
    logic [23:0]        release_growth;
    logic [23:0]        lp_pole;
    logic [31:0]        wet_gain;
    logic [16:0]        dry_gain;
  } cfg_t;

  typedef struct packed {
    logic               load_in;
    logic               lp_step;
    logic               log_step;
    logic               scale_step;
    logic               exp_step;
    logic               hold_step;
    logic               wg_step;
    logic               wet_lo;
    logic               wet_hi;
    logic               load_out;
    logic               ch;
    logic [STAGE_W-1:0] stage;
  } cmd_t;

  // log2(1 + i/16), Q1.16
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // 2^(i/16), Q2.16
  function automatic logic [17:0] exp2_tab(input logic [4:0] i);
    logic [17:0] v;
    case (i)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68437;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120193;
      5'd15:   v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/stereo_highpass_exciter_compressor.sv =====
// Channel   Signals                          Moves
// input     in_valid / in_ready / in_data     one stereo request (left_in, right_in)
// output    out_valid / out_ready / out_data  one stereo result (left_out, right_out)
// config    cfg_we / cfg_index / cfg_data     one register write, no wait
//
// One request occupies the block from acceptance until it is ready again:
// the lowpass sweep takes one stage per cycle, then the gain path steps
// through log, scale, exp, release, wet gain and a low and a high step per
// channel for the split wide product.
// The output register holds a result while the next request is accepted.
// Reset is synchronous: lowpass state clears and the held gain returns to 1.0.
// An output stall only holds the controller in its final step.
module stereo_highpass_exciter_compressor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  shec_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output shec_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [shec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [shec_pkg::CFG_DATA_W-1:0]     cfg_data
);

  shec_pkg::cfg_t cfg;
  shec_pkg::cmd_t cmd;

  // Register file: the user must write it only while idle (not enforced).
  shec_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: steps the datapath and owns both handshakes.
  shec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Filters, gain computer and output mix.
  shec_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== rtl/shec_cfg.sv =====
module shec_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [shec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [shec_pkg::CFG_DATA_W-1:0]     cfg_data,
  output shec_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thresh_lin     <= 25'd16777216;
      cfg.thresh_db      <= '0;
      cfg.release_growth <= 24'd1048576;
      cfg.lp_pole        <= '0;
      cfg.wet_gain       <= 32'd65536;
      cfg.dry_gain       <= 17'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shec_pkg::REG_THRESH_LIN:     cfg.thresh_lin     <= cfg_data[24:0];
        shec_pkg::REG_THRESH_DB:      cfg.thresh_db      <= cfg_data[14:0];
        shec_pkg::REG_RELEASE_GROWTH: cfg.release_growth <= cfg_data[23:0];
        shec_pkg::REG_LP_POLE:        cfg.lp_pole        <= cfg_data[23:0];
        shec_pkg::REG_WET_GAIN:       cfg.wet_gain       <= cfg_data[31:0];
        shec_pkg::REG_DRY_GAIN:       cfg.dry_gain       <= cfg_data[16:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

// ===== rtl/shec_ctrl.sv =====
module shec_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output shec_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LP, ST_LOG, ST_SCALE, ST_EXP, ST_HOLD, ST_WG,
    ST_WET_LO, ST_WET_HI, ST_OUT
  } state_t;

  localparam logic [shec_pkg::STAGE_W-1:0] LAST_STAGE =
    shec_pkg::STAGE_W'(shec_pkg::LP_STAGES - 1);

  state_t                       state;
  logic                         ch;
  logic [shec_pkg::STAGE_W-1:0] stage;
  logic                         out_load;

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    cmd            = '0;
    cmd.ch         = ch;
    cmd.stage      = stage;
    cmd.load_in    = in_ready && in_valid;
    cmd.lp_step    = (state == ST_LP);
    cmd.log_step   = (state == ST_LOG);
    cmd.scale_step = (state == ST_SCALE);
    cmd.exp_step   = (state == ST_EXP);
    cmd.hold_step  = (state == ST_HOLD);
    cmd.wg_step    = (state == ST_WG);
    cmd.wet_lo     = (state == ST_WET_LO);
    cmd.wet_hi     = (state == ST_WET_HI);
    cmd.load_out   = out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ch        <= 1'b0;
      stage     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_LP;
            ch    <= 1'b0;
            stage <= '0;
          end
        end
        ST_LP: begin
          if (stage == LAST_STAGE) begin
            stage <= '0;
            ch    <= ~ch;
            if (ch) begin
              state <= ST_LOG;
            end
          end else begin
            stage <= stage + 1'b1;
          end
        end
        ST_LOG:    state <= ST_SCALE;
        ST_SCALE:  state <= ST_EXP;
        ST_EXP:    state <= ST_HOLD;
        ST_HOLD:   state <= ST_WG;
        ST_WG: begin
          state <= ST_WET_LO;
          ch    <= 1'b0;
        end
        ST_WET_LO: state <= ST_WET_HI;
        ST_WET_HI: begin
          ch <= ~ch;
          if (ch) begin
            state <= ST_OUT;
          end else begin
            state <= ST_WET_LO;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/shec_dp.sv =====
module shec_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  shec_pkg::cfg_t        cfg,
  input  shec_pkg::cmd_t        cmd,
  input  shec_pkg::in_item_t    in_data,
  output shec_pkg::out_item_t   out_data
);

  localparam int SW       = shec_pkg::SAMPLE_WIDTH;
  localparam int UP       = 32 - SW;
  localparam int DOWN     = 48 - SW;
  localparam int LP_IDX_W = $clog2(shec_pkg::NUM_LP);
  localparam int EXP_W    = $clog2(SW);

  localparam logic [shec_pkg::STAGE_W-1:0] LAST_STAGE =
    shec_pkg::STAGE_W'(shec_pkg::LP_STAGES - 1);
  localparam logic signed [65:0] Y_MAX = (66'sd1 <<< (SW - 1)) - 66'sd1;
  localparam logic signed [65:0] Y_MIN = -(66'sd1 <<< (SW - 1));
  localparam logic [67:0]        WET_LIMIT = 68'd1 << 62;

  // held state
  logic signed [SW-1:0] x_l, x_r;
  logic signed [31:0]   chain;
  logic signed [31:0]   lp_state [shec_pkg::NUM_LP];
  logic signed [32:0]   hb_l, hb_r;
  logic                 above;
  logic signed [23:0]   thr_q;
  logic signed [23:0]   diff;
  logic signed [24:0]   g;
  logic [31:0]          seek, held;
  logic [33:0]          wg;
  logic [63:0]          pl;
  logic signed [SW+17:0] dryp;
  logic signed [SW-1:0] res_l, res_r;

  // lowpass step
  logic signed [SW-1:0] x_ch;
  logic signed [31:0]   s_x, s_in, lp_new;
  logic [LP_IDX_W-1:0]  lp_idx;
  logic signed [32:0]   d, hb_new;
  logic signed [57:0]   lp_prod;
  logic signed [58:0]   lp_acc;

  assign x_ch    = cmd.ch ? x_r : x_l;
  assign s_x     = 32'(x_ch) <<< UP;
  assign s_in    = (cmd.stage == '0) ? s_x : chain;
  assign lp_idx  = LP_IDX_W'(cmd.stage) + (cmd.ch ? LP_IDX_W'(shec_pkg::LP_STAGES) : '0);
  assign d       = 33'(lp_state[lp_idx]) - 33'(s_in);
  assign lp_prod = $signed({1'b0, cfg.lp_pole}) * d;
  assign lp_acc  = (59'(s_in) <<< 24) + 59'(lp_prod) + (59'sd1 <<< 23);
  assign lp_new  = lp_acc[55:24];
  assign hb_new  = 33'(s_x) - 33'(lp_new);

  // peak and log2
  logic [SW-1:0]       a_l, a_r, peak;
  logic                above_next;
  logic [EXP_W-1:0]    e;
  logic [SW+15:0]      norm;
  logic [15:0]         frac;
  logic [16:0]         lt0, lt1, lint;
  logic [28:0]         lmul;
  logic signed [23:0]  lp_val;

  assign a_l  = x_l[SW-1] ? SW'(-x_l) : SW'(x_l);
  assign a_r  = x_r[SW-1] ? SW'(-x_r) : SW'(x_r);
  assign peak = (a_l > a_r) ? a_l : a_r;
  assign above_next = {peak, 24'd0} > ((SW + 24)'(cfg.thresh_lin) << (SW - 1));

  always_comb begin
    e = '0;
    for (int k = 0; k < SW; k++) begin
      if (peak[k]) begin
        e = EXP_W'(k);
      end
    end
  end

  assign norm   = {peak, 16'd0} >> e;
  assign frac   = norm[15:0];
  assign lt0    = shec_pkg::log2_tab({1'b0, frac[15:12]});
  assign lt1    = shec_pkg::log2_tab({1'b0, frac[15:12]} + 5'd1);
  assign lmul   = 29'(lt1 - lt0) * 29'(frac[11:0]);
  assign lint   = lt0 + 17'(lmul >> 12);
  assign lp_val = ((24'($signed({1'b0, e})) - 24'(SW - 1)) <<< 16) + 24'({1'b0, lint});

  // threshold in log2 units: round(|thresh_db| * 128 / 3), reciprocal multiply
  logic [14:0] tmag;
  logic [21:0] tnum;
  logic [43:0] tprod;
  logic [20:0] tq;

  assign tmag  = cfg.thresh_db[14] ? 15'(-cfg.thresh_db) : 15'(cfg.thresh_db);
  assign tnum  = {tmag, 7'd0} + 22'd1;
  assign tprod = 44'(tnum) * 44'd2796203;
  assign tq    = tprod[43:23];

  // scale by one minus ratio
  logic signed [40:0] gprod;
  assign gprod = 41'(diff) * 41'sd62259 + 41'sd32768;

  // exp2
  logic signed [8:0] n;
  logic [17:0]       et0, et1, eint;
  logic [29:0]       emul;
  logic [31:0]       v, seek_next;

  assign n    = g[24:16];
  assign et0  = shec_pkg::exp2_tab({1'b0, g[15:12]});
  assign et1  = shec_pkg::exp2_tab({1'b0, g[15:12]} + 5'd1);
  assign emul = 30'(et1 - et0) * 30'(g[11:0]);
  assign eint = et0 + 18'(emul >> 12);
  assign v    = 32'(eint) << 14;

  always_comb begin
    if (!above) begin
      seek_next = 32'h4000_0000;
    end else if (n >= 9'sd2) begin
      seek_next = '1;
    end else if (n == 9'sd1) begin
      seek_next = v << 1;
    end else if (n == 9'sd0) begin
      seek_next = v;
    end else if (n <= -9'sd32) begin
      seek_next = '0;
    end else begin
      seek_next = v >> 5'(-n);
    end
  end

  // release
  logic [55:0] grow_prod;
  logic [31:0] grown, held_next;
  assign grow_prod = 56'(held) * 56'(cfg.release_growth);
  assign grown     = (|grow_prod[55:52]) ? '1 : grow_prod[51:20];
  assign held_next = (held > seek) ? seek : ((grown > seek) ? seek : grown);

  logic [63:0] wg_prod;
  assign wg_prod = 64'(cfg.wet_gain) * 64'(held);

  // wet path
  logic signed [32:0] hb_ch;
  logic [32:0]        mag;
  logic [35:0]        hi;
  logic [67:0]        total;
  logic [62:0]        p;
  logic signed [64:0] wet;
  logic signed [65:0] sum, rnd, y_full;
  logic signed [SW-1:0] y_sat;

  assign hb_ch  = cmd.ch ? hb_r : hb_l;
  assign mag    = hb_ch[32] ? 33'(-hb_ch) : 33'(hb_ch);
  assign hi     = 36'(wg[33:32]) * 36'(mag) + (mag[32] ? 36'(wg[31:0]) : 36'd0);
  assign total  = {hi, 32'd0} + 68'(pl);
  assign p      = (total > WET_LIMIT) ? 63'(WET_LIMIT) : total[62:0];
  assign wet    = hb_ch[32] ? -65'(p) : 65'(p);
  assign sum    = (66'(dryp) <<< UP) + 66'(wet);
  assign rnd    = sum + (66'sd1 <<< (DOWN - 1));
  assign y_full = rnd >>> DOWN;
  assign y_sat  = (y_full > Y_MAX) ? SW'(Y_MAX) :
                  (y_full < Y_MIN) ? SW'(Y_MIN) : SW'(y_full);

  // state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < shec_pkg::NUM_LP; i++) begin
        lp_state[i] <= '0;
      end
      held <= 32'h4000_0000;
    end else begin
      if (cmd.lp_step) begin
        lp_state[lp_idx] <= lp_new;
      end
      if (cmd.hold_step) begin
        held <= held_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    thr_q <= cfg.thresh_db[14] ? -24'(tq) : 24'(tq);
    if (cmd.load_in) begin
      x_l <= in_data.left_in;
      x_r <= in_data.right_in;
    end
    if (cmd.lp_step) begin
      chain <= lp_new;
      if (cmd.stage == LAST_STAGE) begin
        if (cmd.ch) begin
          hb_r <= hb_new;
        end else begin
          hb_l <= hb_new;
        end
      end
    end
    if (cmd.log_step) begin
      above <= above_next;
      diff  <= thr_q - lp_val;
    end
    if (cmd.scale_step) begin
      g <= gprod[40:16];
    end
    if (cmd.exp_step) begin
      seek <= seek_next;
    end
    if (cmd.wg_step) begin
      wg <= wg_prod[63:30];
    end
    if (cmd.wet_lo) begin
      pl   <= 64'(wg[31:0]) * 64'(mag[31:0]);
      dryp <= x_ch * $signed({1'b0, cfg.dry_gain});
    end
    if (cmd.wet_hi) begin
      if (cmd.ch) begin
        res_r <= y_sat;
      end else begin
        res_l <= y_sat;
      end
    end
    if (cmd.load_out) begin
      out_data.left_out  <= res_l;
      out_data.right_out <= res_r;
    end
  end

endmodule

// ===== rtl/shec_checker.sv =====
`include "stereo_highpass_exciter_compressor_macros.svh"

module shec_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input shec_pkg::out_item_t out_data
);

  logic [1:0] pending;

  // Track requests accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  `SHEC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
  `SHEC_ASSERT_SAME(a_no_invent, clk, rst, out_valid, pending != 2'd0, "result without a request")
  `SHEC_ASSERT_ALWAYS(a_bounded, clk, rst, pending <= 2'd2, "too many requests in flight")
  `SHEC_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "accepted a request while busy")

endmodule

bind stereo_highpass_exciter_compressor shec_checker u_shec_checker (.*);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Exciter/compressor predictor and store of expected stereo results.
  class exciter_scoreboard;
    longint lp_state[2*shec_pkg::LP_STAGES];
    bit [31:0] held;
    bit [24:0] th_lin;
    bit signed [14:0] th_db;
    bit [23:0] growth;
    bit [23:0] pole;
    bit [31:0] wet;
    bit [16:0] dry;
    shec_pkg::out_item_t pending[$];
    int errors;

    function new();
      foreach (lp_state[i]) lp_state[i] = 0;
      held = 32'h4000_0000;
      th_lin = 25'd16777216;
      th_db = 0;
      growth = 24'd1048576;
      pole = 0;
      wet = 32'd65536;
      dry = 17'd65536;
      errors = 0;
    endfunction

    function void write_reg(shec_pkg::cfg_reg_t idx, bit [31:0] v);
      case (idx)
        shec_pkg::REG_THRESH_LIN:     th_lin = v[24:0];
        shec_pkg::REG_THRESH_DB:      th_db = v[14:0];
        shec_pkg::REG_RELEASE_GROWTH: growth = v[23:0];
        shec_pkg::REG_LP_POLE:        pole = v[23:0];
        shec_pkg::REG_WET_GAIN:       wet = v;
        shec_pkg::REG_DRY_GAIN:       dry = v[16:0];
        default: ;
      endcase
    endfunction

    // floor division by a power of two
    function longint fshr(longint v, int s);
      return v >>> s;
    endfunction

    function longint lerp(bit is_exp, longint x16);
      longint i, r, a, b;
      i = (x16 >> 12) & 15;
      r = x16 & 4095;
      a = is_exp ? exp2_val(i) : log2_val(i);
      b = is_exp ? exp2_val(i + 1) : log2_val(i + 1);
      return a + (((b - a) * r) >> 12);
    endfunction

    function longint log2_val(longint i);
      longint t[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
                        42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
      return t[i];
    endfunction

    function longint exp2_val(longint i);
      longint t[17] = '{65536, 68437, 71468, 74632, 77936, 81386, 84990, 88752,
                        92682, 96785, 101070, 105545, 110218, 115098, 120193,
                        125515, 131072};
      return t[i];
    endfunction

    function bit [31:0] compute_target(longint pk);
      int e;
      longint lg, thr, g, n, mag;
      bit [63:0] v;
      e = 0;
      while (e < 63 && (pk >> (e + 1)) != 0) e++;
      lg = (e - (shec_pkg::SAMPLE_WIDTH - 1)) * 65536 + lerp(0, ((pk << 16) >> e) - 65536);
      mag = (th_db < 0) ? -longint'(th_db) : longint'(th_db);
      thr = (mag * 128 + 1) / 3;
      if (th_db < 0) thr = -thr;
      g = fshr((thr - lg) * 62259 + 32768, 16);
      n = fshr(g, 16);
      v = lerp(1, g & 16'hFFFF) << 14;
      if (n >= 2) return 32'hFFFF_FFFF;
      if (n == 1) return v[31:0] << 1;
      if (n == 0) return v[31:0];
      if (n <= -32) return 0;
      return v[31:0] >> (-n);
    endfunction

    // Note an accepted request and queue the result it must cause.
    function void note_request(shec_pkg::in_item_t it);
      longint x[2], hb[2], s, acc, pk, a0, a1, ymag, p, w, sum, y, lim;
      bit [63:0] seek, grown, wg;
      shec_pkg::out_item_t r;
      x[0] = it.left_in;
      x[1] = it.right_in;
      for (int ch = 0; ch < 2; ch++) begin
        s = x[ch] <<< 8;
        for (int k = 0; k < shec_pkg::LP_STAGES; k++) begin
          acc = (16777216 - longint'(pole)) * s +
                longint'(pole) * lp_state[ch*shec_pkg::LP_STAGES+k];
          lp_state[ch*shec_pkg::LP_STAGES+k] = fshr(acc + 8388608, 24);
          s = lp_state[ch*shec_pkg::LP_STAGES+k];
        end
        hb[ch] = (x[ch] <<< 8) - s;
      end
      a0 = x[0] < 0 ? -x[0] : x[0];
      a1 = x[1] < 0 ? -x[1] : x[1];
      pk = a0 > a1 ? a0 : a1;
      if ((pk << 24) > (longint'(th_lin) << (shec_pkg::SAMPLE_WIDTH - 1)))
        seek = compute_target(pk);
      else seek = 32'h4000_0000;
      if (held > seek) held = seek[31:0];
      else begin
        grown = (64'(held) * growth) >> 20;
        if (grown > 64'hFFFF_FFFF) grown = 64'hFFFF_FFFF;
        if (grown > seek) grown = seek;
        held = grown[31:0];
      end
      wg = (64'(wet) * held) >> 30;
      lim = longint'(1) << (shec_pkg::SAMPLE_WIDTH - 1);
      for (int ch = 0; ch < 2; ch++) begin
        ymag = hb[ch] < 0 ? -hb[ch] : hb[ch];
        if (ymag != 0 && wg > (64'h4000_0000_0000_0000 / ymag)) p = 64'h4000_0000_0000_0000;
        else p = wg * ymag;
        w = hb[ch] < 0 ? -p : p;
        sum = x[ch] * longint'(dry) * 256 + w;
        y = fshr(sum + (longint'(1) << 23), 24);
        if (y > lim - 1) y = lim - 1;
        if (y < -lim) y = -lim;
        if (ch == 0) r.left_out = y[23:0];
        else r.right_out = y[23:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(shec_pkg::out_item_t got);
      shec_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.left_out !== want.left_out) begin
        $error("left_out expected %0d actual %0d", want.left_out, got.left_out);
        errors++;
      end
      if (got.right_out !== want.right_out) begin
        $error("right_out expected %0d actual %0d", want.right_out, got.right_out);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  shec_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  shec_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [shec_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [shec_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  exciter_scoreboard sb = new();
  int idle_cycles = 0;
  int out_wait = 0;
  bit stall_free = 0;

  always #4 clk = ~clk;

  stereo_highpass_exciter_compressor uut (.*);

  // Check every accepted result; wait a drawn number of cycles before the next.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        out_wait = stall_free ? 0 : $urandom_range(0, 14);
      end else if (out_wait > 0) begin
        out_wait = out_wait - 1;
      end
      out_ready <= (out_wait == 0);
    end
  end

  // Watchdog: count cycles with no request or result moving.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_sample(logic signed [23:0] l, logic signed [23:0] r);
    shec_pkg::in_item_t it;
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    it.left_in = l;
    it.right_in = r;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  // Write a register once the block has drained.
  task automatic write_reg(shec_pkg::cfg_reg_t idx, logic [31:0] v);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  function automatic logic signed [23:0] rnd_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return 24'($urandom_range(0, 2047) - 1024);
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes at reset settings.
    send_sample(24'sh7FFFFF, 24'sh800000);
    send_sample(24'sh800000, 24'sh7FFFFF);
    send_sample(24'sh000000, 24'sh000000);
    send_sample(24'sh000001, 24'shFFFFFF);
    send_sample(24'sh555555, 24'shAAAAAA);

    // Heavy compression, large wet gain overflow, instant release.
    write_reg(shec_pkg::REG_THRESH_LIN, 32'd1);
    write_reg(shec_pkg::REG_THRESH_DB, 32'h4400);
    write_reg(shec_pkg::REG_LP_POLE, 32'hFFFFFF);
    write_reg(shec_pkg::REG_WET_GAIN, 32'hFFFF_FFFF);
    write_reg(shec_pkg::REG_RELEASE_GROWTH, 32'hFFFFFF);
    write_reg(shec_pkg::REG_DRY_GAIN, 32'd0);
    send_sample(24'sh7FFFFF, 24'sh000010);
    send_sample(24'sh800000, 24'sh7FFFFF);
    send_sample(24'sh000003, 24'sh000000);
    send_sample(24'sh000000, 24'shFFFFFE);
    // Growth below one, positive dB threshold (large gain target).
    write_reg(shec_pkg::REG_RELEASE_GROWTH, 32'd1000);
    write_reg(shec_pkg::REG_THRESH_DB, 32'h3FFF);
    write_reg(shec_pkg::REG_DRY_GAIN, 32'h1FFFF);
    send_sample(24'sh400000, 24'sh100000);
    send_sample(24'sh000002, 24'sh7FFFFF);

    // Hold off until every expected result has come.
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);

    // Random phases across settings.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(shec_pkg::REG_THRESH_LIN,
                (ph == 9) ? 32'h1FFFFFF : $urandom_range(0, 16777216));
      write_reg(shec_pkg::REG_THRESH_DB, (ph == 1) ? 32'h4400 : -$urandom_range(0, 15360));
      write_reg(shec_pkg::REG_RELEASE_GROWTH, $urandom_range(1048576, 16777215));
      write_reg(shec_pkg::REG_LP_POLE, (ph == 2) ? 32'd0 : $urandom_range(0, 16777215));
      write_reg(shec_pkg::REG_WET_GAIN,
                (ph == 3) ? 32'hFFFF_FFFF : $urandom_range(0, 1 << 20));
      write_reg(shec_pkg::REG_DRY_GAIN, $urandom_range(0, 65536));
      write_reg(shec_pkg::cfg_reg_t'(3'd6 + ph % 2), $urandom);
      stall_free = (ph == 4);
      for (int n = 0; n < 125; n++) send_sample(rnd_sample(), rnd_sample());
    end
    stall_free = 0;

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
